// ===== sv/sdt_pkg.sv =====
// ----------------------------------------------------------------------------
// sdt_pkg: shared types and constants of the segment duration timer
// Field widths, fixed-point format, phase codes and register indexes.
// ----------------------------------------------------------------------------
package sdt_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_W    = 16;                  // fractional bits, Q0.16
    localparam int COUNT_W   = 32;                  // position / length width
    localparam int DRIFT_W   = 24;                  // drift, Q8.16
    localparam int VALUE_W   = 32;                  // value and factor, Q16.16
    localparam int RATE_W    = 18;                  // sample rate
    localparam int MODE_W    = 2;
    localparam int PHASE_W   = 2;
    localparam int CFG_W     = 32;                  // widest register
    localparam int CFG_IDX_W = 3;

    // Serial arithmetic: shift-add multiply, restoring divide
    localparam int MUL_STEPS = VALUE_W;
    localparam int QUO_W     = RATE_W + 2 * FRAC_W; // (rate << 2F) / value
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [DRIFT_W-1:0] DRIFT_ONE = DRIFT_W'(1) << FRAC_W;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_START    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PROGRESS = 2'd1;
    localparam logic [PHASE_W-1:0] PH_END      = 2'd2;

    // Length source modes (any other code acts as fixed)
    localparam logic [MODE_W-1:0] MODE_FIXED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MUL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIV   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIX_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIX_FRAC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 3'd4;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    // Where a new segment length comes from
    typedef enum logic [1:0] {
        SRC_FIXED = 2'd0,
        SRC_MUL   = 2'd1,
        SRC_DIV   = 2'd2,
        SRC_SAT   = 2'd3
    } t_src;

endpackage

// ===== sv/sdt_if.sv =====
// ----------------------------------------------------------------------------
// sdt_if: valid/ready channels of the segment duration timer
// Item channel (tick or restart) and result channel.
// ----------------------------------------------------------------------------
interface sdt_item_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [sdt_pkg::DRIFT_W-1:0]    drift_in;
    logic [sdt_pkg::VALUE_W-1:0]    value_in;

    modport source (output valid, command, drift_in, value_in, input ready);
    modport sink   (input valid, command, drift_in, value_in, output ready);
endinterface

interface sdt_result_if;
    logic                           valid;
    logic                           ready;
    logic [sdt_pkg::DRIFT_W-1:0]    drift_out;
    logic [sdt_pkg::PHASE_W-1:0]    phase;
    logic [sdt_pkg::COUNT_W-1:0]    position;
    logic [sdt_pkg::COUNT_W-1:0]    length;
    logic                           started;

    modport source (output valid, drift_out, phase, position, length, started,
                    input ready);
    modport sink   (input valid, drift_out, phase, position, length, started,
                    output ready);
endinterface

// ===== sv/segment_duration_timer_with_drift_unit.sv =====
// ----------------------------------------------------------------------------
// segment_duration_timer_with_drift_unit: sample-tick segment timer
// Counts ticks through a segment whose length comes from a fixed register,
// value times factor, or sample rate divided by value, carrying fraction drift.
// ----------------------------------------------------------------------------
// One transfer in per tick or restart, one transfer out per item. A plain tick
// or restart is captured, then updated. A tick that starts a segment goes
// straight to the update in fixed mode (or with a zero divisor); in
// value-times-factor mode a bit-serial shift-add multiplier does 32 steps
// first, and in rate-over-value mode a bit-serial restoring divider produces
// 50 quotient bits (34 whole, 16 fraction) first. A new item is
// taken as soon as the controller is idle, even if the previous result has
// not been transferred out yet; the update step waits for the output register
// to free up. Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data
// and must only change while no item is in flight.
// ----------------------------------------------------------------------------
module segment_duration_timer_with_drift_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sdt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sdt_pkg::CFG_W-1:0]       i_cfg_data,
    sdt_item_if.sink                        i_item,
    sdt_result_if.source                    o_result
);

    localparam int FW = sdt_pkg::FRAC_W;
    localparam int CW = sdt_pkg::COUNT_W;
    localparam int DW = sdt_pkg::DRIFT_W;
    localparam int VW = sdt_pkg::VALUE_W;
    localparam int QW = sdt_pkg::QUO_W;
    localparam int SW = sdt_pkg::STEP_W;

    // Configuration registers
    logic [sdt_pkg::MODE_W-1:0]  r_mode;
    logic [CW-1:0]               r_fix_len;
    logic [FW-1:0]               r_fix_frac;
    logic [VW-1:0]               r_factor;
    logic [sdt_pkg::RATE_W-1:0]  r_rate;

    // Controller
    sdt_pkg::t_state             r_state;
    logic [SW-1:0]               r_cnt;
    sdt_pkg::t_src               r_src;
    logic                        r_start;

    // Captured item
    logic                        r_cmd;
    logic [DW-1:0]               r_drift;
    logic [VW-1:0]               r_value;

    // Serial arithmetic
    logic [2*VW-1:0]             r_prod;   // multiplier in low half at start
    logic [QW-1:0]               r_quo;    // dividend shifts out, quotient in
    logic [VW-1:0]               r_rem;

    // Timer state (the segment fraction is only needed on the start tick)
    logic [sdt_pkg::PHASE_W-1:0] r_phase;
    logic [CW-1:0]               r_pos;
    logic [CW-1:0]               r_length;

    // Output register
    logic                        r_out_valid;
    logic [DW-1:0]               r_out_drift;
    logic [sdt_pkg::PHASE_W-1:0] r_out_phase;
    logic [CW-1:0]               r_out_pos;
    logic [CW-1:0]               r_out_len;
    logic                        r_out_started;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= sdt_pkg::MODE_FIXED;
            r_fix_len  <= CW'(1);
            r_fix_frac <= '0;
            r_factor   <= VW'(65536);
            r_rate     <= sdt_pkg::RATE_W'(48000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sdt_pkg::CFG_MODE:       r_mode     <= i_cfg_data[sdt_pkg::MODE_W-1:0];
                sdt_pkg::CFG_FIX_LENGTH: r_fix_len  <= i_cfg_data[CW-1:0];
                sdt_pkg::CFG_FIX_FRAC:   r_fix_frac <= i_cfg_data[FW-1:0];
                sdt_pkg::CFG_FACTOR:     r_factor   <= i_cfg_data[VW-1:0];
                sdt_pkg::CFG_RATE:       r_rate     <= i_cfg_data[sdt_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic c_acc;
    logic c_begin;
    logic c_out_free;
    logic c_fin;

    assign i_item.ready = (r_state == sdt_pkg::ST_IDLE);
    assign c_acc        = i_item.valid && i_item.ready;
    // a tick in the start phase opens a new segment
    assign c_begin      = !i_item.command && (r_phase == sdt_pkg::PH_START);
    assign c_out_free   = !r_out_valid || o_result.ready;
    assign c_fin        = (r_state == sdt_pkg::ST_FIN) && c_out_free;

    assign o_result.valid     = r_out_valid;
    assign o_result.drift_out = r_out_drift;
    assign o_result.phase     = r_out_phase;
    assign o_result.position  = r_out_pos;
    assign o_result.length    = r_out_len;
    assign o_result.started   = r_out_started;

    // ------------------------------------------------------------------
    // Serial step logic
    // ------------------------------------------------------------------
    logic [VW:0]   c_mul_hi;
    logic [VW:0]   c_div_sh;
    logic [VW+1:0] c_div_diff;
    logic          c_div_ge;

    // shift-add: add factor to the upper half when the multiplier LSB is set
    assign c_mul_hi   = {1'b0, r_prod[2*VW-1:VW]}
                      + (r_prod[0] ? {1'b0, r_factor} : '0);
    // restoring divide: bring down next dividend bit, subtract if it fits
    assign c_div_sh   = {r_rem, r_quo[QW-1]};
    assign c_div_diff = {1'b0, c_div_sh} - {2'b0, r_value};
    assign c_div_ge   = !c_div_diff[VW+1];

    // ------------------------------------------------------------------
    // Segment update
    // ------------------------------------------------------------------
    logic [CW-1:0] c_src_len;
    logic [FW-1:0] c_src_frac;
    logic          c_src_ovf;
    logic [CW-1:0] c_new_len;
    logic [FW-1:0] c_new_frac;
    logic [CW-1:0] c_len;
    logic [DW:0]   c_dsum;
    logic [DW-1:0] c_drift_a;
    logic [CW-1:0] c_pos_a;
    logic          c_more;
    logic          c_owed;
    logic [DW-1:0] n_drift;
    logic [sdt_pkg::PHASE_W-1:0] n_phase;
    logic [CW-1:0] n_pos;

    always_comb begin
        c_src_ovf = 1'b0;
        unique case (r_src)
            sdt_pkg::SRC_MUL: begin
                c_src_len  = r_prod[2*VW-1:VW];
                c_src_frac = r_prod[VW-1:VW-FW];
            end
            sdt_pkg::SRC_DIV: begin
                // quotient whole part has more bits than a length can hold
                c_src_ovf  = |r_quo[QW-1:FW+CW];
                c_src_len  = r_quo[FW+CW-1:FW];
                c_src_frac = r_quo[FW-1:0];
            end
            sdt_pkg::SRC_SAT: begin
                c_src_len  = '1;
                c_src_frac = '0;
            end
            default: begin
                c_src_len  = r_fix_len;
                c_src_frac = r_fix_frac;
            end
        endcase

        if (c_src_ovf) begin
            c_new_len  = '1;
            c_new_frac = '0;
        end else if (c_src_len == '0) begin
            c_new_len  = CW'(1);
            c_new_frac = '0;
        end else begin
            c_new_len  = c_src_len;
            c_new_frac = c_src_frac;
        end

        c_len  = r_start ? c_new_len : r_length;
        c_dsum = {1'b0, r_drift} + (DW+1)'(c_new_frac);
        if (r_start) begin
            c_drift_a = c_dsum[DW] ? '1 : c_dsum[DW-1:0];
            c_pos_a   = '0;
        end else begin
            c_drift_a = r_drift;
            c_pos_a   = r_pos;
        end

        c_more = c_pos_a < (c_len - CW'(1));
        c_owed = c_drift_a >= sdt_pkg::DRIFT_ONE;

        // drift of a whole tick or more buys one extra tick at the last spot
        priority if (c_more) begin
            n_phase = sdt_pkg::PH_PROGRESS;
            n_pos   = c_pos_a + CW'(1);
            n_drift = c_drift_a;
        end else if (c_owed) begin
            n_phase = sdt_pkg::PH_PROGRESS;
            n_pos   = c_pos_a;
            n_drift = c_drift_a - sdt_pkg::DRIFT_ONE;
        end else begin
            n_phase = sdt_pkg::PH_END;
            n_pos   = c_pos_a + CW'(1);
            n_drift = c_drift_a;
        end
    end

    // ------------------------------------------------------------------
    // Controller and timer state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdt_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_src       <= sdt_pkg::SRC_FIXED;
            r_start     <= 1'b0;
            r_phase     <= sdt_pkg::PH_START;
            r_pos       <= '0;
            r_length    <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (c_fin) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                sdt_pkg::ST_IDLE: begin
                    if (c_acc) begin
                        r_start <= c_begin;
                        if (c_begin && (r_mode == sdt_pkg::MODE_MUL)) begin
                            r_src   <= sdt_pkg::SRC_MUL;
                            r_cnt   <= SW'(sdt_pkg::MUL_STEPS - 1);
                            r_state <= sdt_pkg::ST_MUL;
                        end else if (c_begin && (r_mode == sdt_pkg::MODE_DIV)
                                     && (i_item.value_in != '0)) begin
                            r_src   <= sdt_pkg::SRC_DIV;
                            r_cnt   <= SW'(sdt_pkg::DIV_STEPS - 1);
                            r_state <= sdt_pkg::ST_DIV;
                        end else if (c_begin && (r_mode == sdt_pkg::MODE_DIV)) begin
                            // zero divisor saturates the length
                            r_src   <= sdt_pkg::SRC_SAT;
                            r_state <= sdt_pkg::ST_FIN;
                        end else begin
                            r_src   <= sdt_pkg::SRC_FIXED;
                            r_state <= sdt_pkg::ST_FIN;
                        end
                    end
                end
                sdt_pkg::ST_MUL, sdt_pkg::ST_DIV: begin
                    r_cnt <= r_cnt - SW'(1);
                    if (r_cnt == '0) begin
                        r_state <= sdt_pkg::ST_FIN;
                    end
                end
                sdt_pkg::ST_FIN: begin
                    if (c_out_free) begin
                        r_state <= sdt_pkg::ST_IDLE;
                        if (r_cmd) begin
                            r_phase <= sdt_pkg::PH_START;
                            r_pos   <= '0;
                        end else begin
                            r_phase <= n_phase;
                            r_pos   <= n_pos;
                            if (r_start) begin
                                r_length <= c_new_len;
                            end
                        end
                    end
                end
                default: r_state <= sdt_pkg::ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (c_acc) begin
            r_cmd   <= i_item.command;
            r_drift <= i_item.drift_in;
            r_value <= i_item.value_in;
            r_prod  <= {{VW{1'b0}}, i_item.value_in};
            r_quo   <= {r_rate, {(2*FW){1'b0}}};
            r_rem   <= '0;
        end else if (r_state == sdt_pkg::ST_MUL) begin
            r_prod <= {c_mul_hi, r_prod[VW-1:1]};
        end else if (r_state == sdt_pkg::ST_DIV) begin
            r_rem <= c_div_ge ? c_div_diff[VW-1:0] : c_div_sh[VW-1:0];
            r_quo <= {r_quo[QW-2:0], c_div_ge};
        end

        if (c_fin) begin
            if (r_cmd) begin
                // restart: drift passes through, stored length is reported
                r_out_drift   <= r_drift;
                r_out_phase   <= sdt_pkg::PH_START;
                r_out_pos     <= '0;
                r_out_len     <= r_length;
                r_out_started <= 1'b0;
            end else begin
                r_out_drift   <= n_drift;
                r_out_phase   <= n_phase;
                r_out_pos     <= n_pos;
                r_out_len     <= c_len;
                r_out_started <= r_start;
            end
        end
    end

endmodule

// ===== sim/tb_segment_duration_timer_with_drift_unit.sv =====
// ----------------------------------------------------------------------------
// tb_segment_duration_timer_with_drift_unit: self-checking bench
// Drives ticks and restarts through the item channel, keeps a cycle-free
// model of the segment timer, and checks every result transfer in order.
// Directed tests cover the three length sources and their corner cases.
// Randomized segments under changing settings follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_segment_duration_timer_with_drift_unit;

    // Item command codes and the spare mode code (acts as fixed)
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;
    localparam logic [sdt_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic [sdt_pkg::DRIFT_W-1:0] DRIFT_SAT = '1;
    localparam logic [sdt_pkg::COUNT_W-1:0] COUNT_SAT = '1;
    localparam int RANDOM_ITEMS = 500;
    localparam int BLOCK_ITEMS  = 70;     // random items per setting

    typedef struct packed {
        logic [sdt_pkg::DRIFT_W-1:0] drift_out;
        logic [sdt_pkg::PHASE_W-1:0] phase;
        logic [sdt_pkg::COUNT_W-1:0] position;
        logic [sdt_pkg::COUNT_W-1:0] length;
        logic                        started;
    } t_timer_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [sdt_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [sdt_pkg::CFG_W-1:0]     i_cfg_data;

    sdt_item_if   tick_ch ();
    sdt_result_if res_ch ();

    segment_duration_timer_with_drift_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (tick_ch),
        .o_result   (res_ch)
    );

    // Model copy of the registers and the timer state
    logic [sdt_pkg::MODE_W-1:0]  cfg_mode;
    logic [sdt_pkg::COUNT_W-1:0] cfg_fix_len;
    logic [sdt_pkg::FRAC_W-1:0]  cfg_fix_frac;
    logic [sdt_pkg::VALUE_W-1:0] cfg_factor;
    logic [sdt_pkg::RATE_W-1:0]  cfg_rate;
    logic [sdt_pkg::PHASE_W-1:0] tm_phase;
    logic [sdt_pkg::COUNT_W-1:0] tm_pos;
    logic [sdt_pkg::COUNT_W-1:0] tm_len;
    logic [sdt_pkg::FRAC_W-1:0]  tm_frac;

    t_timer_result pending_results[$];
    int unsigned   mismatch_count = 0;
    bit            idle_on = 1'b1;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Below one tick gives length 1 and no fraction; above the counter range
    // saturates, also without fraction.
    function automatic void set_segment_length(logic [63:0] whole,
                                               logic [sdt_pkg::FRAC_W-1:0] frac);
        if (whole == 64'd0) begin
            tm_len  = 1;
            tm_frac = '0;
        end else if (whole > 64'(COUNT_SAT)) begin
            tm_len  = COUNT_SAT;
            tm_frac = '0;
        end else begin
            tm_len  = whole[sdt_pkg::COUNT_W-1:0];
            tm_frac = frac;
        end
    endfunction

    // One item through the timer: updates the model and returns its result
    function automatic t_timer_result advance_timer(
            logic cmd,
            logic [sdt_pkg::DRIFT_W-1:0] drift_in,
            logic [sdt_pkg::VALUE_W-1:0] value);
        t_timer_result r;
        logic [sdt_pkg::DRIFT_W:0] drift;
        logic [63:0] prod;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] fq;
        drift     = {1'b0, drift_in};
        r.started = 1'b0;
        if (cmd == CMD_RESTART) begin
            tm_phase = sdt_pkg::PH_START;
            tm_pos   = '0;
        end else begin
            if (tm_phase == sdt_pkg::PH_START) begin
                r.started = 1'b1;
                if (cfg_mode == sdt_pkg::MODE_MUL) begin
                    prod = 64'(value) * 64'(cfg_factor);
                    set_segment_length(prod >> (2 * sdt_pkg::FRAC_W),
                                       prod[2*sdt_pkg::FRAC_W-1:sdt_pkg::FRAC_W]);
                end else if (cfg_mode == sdt_pkg::MODE_DIV) begin
                    if (value == '0) begin
                        tm_len  = COUNT_SAT;
                        tm_frac = '0;
                    end else begin
                        num = 64'(cfg_rate) << sdt_pkg::FRAC_W;
                        rem = num % 64'(value);
                        fq  = (rem << sdt_pkg::FRAC_W) / 64'(value);
                        set_segment_length(num / 64'(value), fq[sdt_pkg::FRAC_W-1:0]);
                    end
                end else begin
                    set_segment_length(64'(cfg_fix_len), cfg_fix_frac);
                end
                tm_pos = '0;
                drift  = drift + tm_frac;
                if (drift > {1'b0, DRIFT_SAT}) drift = {1'b0, DRIFT_SAT};
            end
            if (tm_pos < tm_len - 1) begin
                tm_phase = sdt_pkg::PH_PROGRESS;
                tm_pos   = tm_pos + 1;
            end else if (drift >= {1'b0, sdt_pkg::DRIFT_ONE}) begin
                // whole tick of drift paid off by one extra tick
                tm_phase = sdt_pkg::PH_PROGRESS;
                drift    = drift - {1'b0, sdt_pkg::DRIFT_ONE};
            end else begin
                tm_phase = sdt_pkg::PH_END;
                tm_pos   = tm_pos + 1;
            end
        end
        r.drift_out = drift[sdt_pkg::DRIFT_W-1:0];
        r.phase     = tm_phase;
        r.position  = tm_pos;
        r.length    = tm_len;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Scoreboard: results are checked before new items are predicted, so
    // the order within one edge is fixed.
    always @(posedge i_clk) begin : scoreboard
        t_timer_result want;
        if (!i_rst_n) begin
            cfg_mode     = sdt_pkg::MODE_FIXED;
            cfg_fix_len  = 1;
            cfg_fix_frac = '0;
            cfg_factor   = 32'd65536;
            cfg_rate     = 18'd48000;
            tm_phase     = sdt_pkg::PH_START;
            tm_pos       = '0;
            tm_len       = 1;
            tm_frac      = '0;
            pending_results.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, got 0x%0h",
                             $time, {res_ch.drift_out, res_ch.phase, res_ch.position,
                                     res_ch.length, res_ch.started});
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("drift_out", 64'(want.drift_out), 64'(res_ch.drift_out));
                    check_field("phase",     64'(want.phase),     64'(res_ch.phase));
                    check_field("position",  64'(want.position),  64'(res_ch.position));
                    check_field("length",    64'(want.length),    64'(res_ch.length));
                    check_field("started",   64'(want.started),   64'(res_ch.started));
                end
            end
            if (tick_ch.valid && tick_ch.ready)
                pending_results.push_back(advance_timer(tick_ch.command,
                                                        tick_ch.drift_in,
                                                        tick_ch.value_in));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sdt_pkg::CFG_MODE:
                        cfg_mode     = i_cfg_data[sdt_pkg::MODE_W-1:0];
                    sdt_pkg::CFG_FIX_LENGTH:
                        cfg_fix_len  = i_cfg_data[sdt_pkg::COUNT_W-1:0];
                    sdt_pkg::CFG_FIX_FRAC:
                        cfg_fix_frac = i_cfg_data[sdt_pkg::FRAC_W-1:0];
                    sdt_pkg::CFG_FACTOR:
                        cfg_factor   = i_cfg_data[sdt_pkg::VALUE_W-1:0];
                    sdt_pkg::CFG_RATE:
                        cfg_rate     = i_cfg_data[sdt_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        res_ch.ready <= !(idle_on && $urandom_range(99) < 7);
    end

    // Drive one item and hold it until its transfer. Valid stays high on
    // return so back-to-back items need no second assignment in one step.
    task automatic send_item(input logic cmd, input logic [sdt_pkg::DRIFT_W-1:0] drift,
                             input logic [sdt_pkg::VALUE_W-1:0] value);
        while (idle_on && $urandom_range(99) < 7) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid    <= 1'b1;
        tick_ch.command  <= cmd;
        tick_ch.drift_in <= drift;
        tick_ch.value_in <= value;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted result has been checked
    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sdt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sdt_pkg::CFG_W-1:0] data);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly below one tick so segments can end, sometimes large
    function automatic logic [sdt_pkg::DRIFT_W-1:0] pick_drift();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) return sdt_pkg::DRIFT_W'($urandom_range(0, 32'hFFFF));
        else if (roll < 80) return sdt_pkg::DRIFT_W'($urandom_range(0, 32'h3FFFF));
        return sdt_pkg::DRIFT_W'($urandom);
    endfunction

    task automatic test_fixed_mode();
        // reset settings: length 1, a second tick lands past the end
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_TICK, '0, '1);
        // zero length acts as 1, spare mode acts as fixed, drift saturates
        write_reg(sdt_pkg::CFG_FIX_LENGTH, '0);
        write_reg(sdt_pkg::CFG_FIX_FRAC, sdt_pkg::CFG_W'(16'hFFFF));
        write_reg(sdt_pkg::CFG_MODE, sdt_pkg::CFG_W'(MODE_SPARE));
        send_item(CMD_RESTART, DRIFT_SAT, '1);
        send_item(CMD_TICK, DRIFT_SAT, '0);
        send_item(CMD_TICK, sdt_pkg::DRIFT_W'(24'h00FFFF), '1);
        // longest fixed segment
        write_reg(sdt_pkg::CFG_FIX_LENGTH, '1);
        send_item(CMD_RESTART, '0, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_TICK, DRIFT_SAT, '1);
    endtask

    task automatic test_mul_mode();
        write_reg(sdt_pkg::CFG_MODE, sdt_pkg::CFG_W'(sdt_pkg::MODE_MUL));
        write_reg(sdt_pkg::CFG_FACTOR, '0);
        send_item(CMD_RESTART, '0, '0);
        send_item(CMD_TICK, '0, '1);            // product zero: length 1
        write_reg(sdt_pkg::CFG_FACTOR, '1);
        send_item(CMD_RESTART, '0, '0);
        send_item(CMD_TICK, '0, '1);            // largest product
        send_item(CMD_RESTART, '0, '0);
        send_item(CMD_TICK, DRIFT_SAT, '0);     // zero value: length 1
    endtask

    task automatic test_div_mode();
        write_reg(sdt_pkg::CFG_MODE, sdt_pkg::CFG_W'(sdt_pkg::MODE_DIV));
        write_reg(sdt_pkg::CFG_RATE, sdt_pkg::CFG_W'(18'h3FFFF));
        send_item(CMD_RESTART, '0, '0);
        send_item(CMD_TICK, '0, '0);            // zero divisor saturates
        send_item(CMD_RESTART, '0, '0);
        send_item(CMD_TICK, '0, 32'd1);         // quotient beyond counter range
        write_reg(sdt_pkg::CFG_RATE, sdt_pkg::CFG_W'(18'd1));
        send_item(CMD_RESTART, '0, '0);
        send_item(CMD_TICK, '0, '1);            // quotient below one
        send_item(CMD_RESTART, '0, '0);
        send_item(CMD_TICK, '0, 32'h8000);      // rate 1 over 0.5: length 2
        send_item(CMD_TICK, sdt_pkg::DRIFT_ONE, '0); // last position, drift buys a tick
        send_item(CMD_TICK, '0, '0);            // now it ends
    endtask

    // Restart, a start tick with a value aimed at a short segment, then a
    // run of ticks; a few broken sequences and fully random values mixed in.
    task automatic test_random_segments();
        int unsigned rand_items;
        int unsigned setting;
        int unsigned block_items;
        int unsigned seg_len;
        int unsigned n_ticks;
        int roll;
        logic [sdt_pkg::MODE_W-1:0]  mode;
        logic [sdt_pkg::RATE_W-1:0]  rate;
        logic [sdt_pkg::VALUE_W-1:0] value;
        logic [63:0]                 divisor;
        rand_items = 0;
        setting    = 0;
        while (rand_items < RANDOM_ITEMS) begin
            mode = sdt_pkg::MODE_W'($urandom_range(0, 3));
            roll = $urandom_range(99);
            rate = (roll < 80) ? sdt_pkg::RATE_W'($urandom_range(8000, 96000))
                               : sdt_pkg::RATE_W'($urandom_range(1, 262143));
            write_reg(sdt_pkg::CFG_MODE, sdt_pkg::CFG_W'(mode));
            roll = $urandom_range(99);
            write_reg(sdt_pkg::CFG_FIX_LENGTH,
                      (roll < 85) ? sdt_pkg::CFG_W'($urandom_range(1, 6)) :
                      (roll < 90) ? sdt_pkg::CFG_W'(0) : sdt_pkg::CFG_W'($urandom));
            write_reg(sdt_pkg::CFG_FIX_FRAC, sdt_pkg::CFG_W'($urandom_range(0, 65535)));
            roll = $urandom_range(99);
            write_reg(sdt_pkg::CFG_FACTOR,
                      (roll < 70) ? sdt_pkg::CFG_W'($urandom_range(32768, 131072))
                                  : sdt_pkg::CFG_W'($urandom));
            write_reg(sdt_pkg::CFG_RATE, sdt_pkg::CFG_W'(rate));
            idle_on     = (setting != 1);   // one setting runs with no gaps at all
            block_items = 0;
            while (block_items < BLOCK_ITEMS) begin
                seg_len = $urandom_range(1, 6);
                case (mode)
                    sdt_pkg::MODE_MUL: value = {16'(seg_len), 16'($urandom)};
                    sdt_pkg::MODE_DIV: begin
                        divisor = (64'(rate) << sdt_pkg::FRAC_W) / 64'(seg_len)
                                  + 64'($urandom_range(0, 255));
                        value = (divisor > 64'hFFFF_FFFF) ? '1
                                : divisor[sdt_pkg::VALUE_W-1:0];
                    end
                    default: value = $urandom;
                endcase
                if ($urandom_range(99) < 15) value = $urandom;
                if ($urandom_range(99) < 80) begin
                    send_item(CMD_RESTART, pick_drift(), $urandom);
                    block_items++;
                end
                send_item(CMD_TICK, pick_drift(), value);
                block_items++;
                n_ticks = $urandom_range(0, 9);
                repeat (n_ticks) begin
                    send_item(($urandom_range(99) < 5) ? CMD_RESTART : CMD_TICK,
                              pick_drift(), $urandom);
                    block_items++;
                end
            end
            rand_items += block_items;
            setting++;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= sdt_pkg::CFG_MODE;
        i_cfg_data       <= '0;
        tick_ch.valid    <= 1'b0;
        tick_ch.command  <= CMD_TICK;
        tick_ch.drift_in <= '0;
        tick_ch.value_in <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fixed_mode();
        test_mul_mode();
        test_div_mode();
        test_random_segments();

        drain_results();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** segment_duration_timer_with_drift_unit: PASSED **");
        end else begin
            $display("** segment_duration_timer_with_drift_unit: FAILED **");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("** segment_duration_timer_with_drift_unit: FAILED **");
        $finish;
    end

endmodule
